/* design/lfps_pkg.sv */
// ----------------------------------------------------------------------------
// lfps_pkg: shared types and constants for the line-follow PID steering block
// Command codes, action codes, register indexes, field widths and the
// configuration bundle handed from the register file to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

  localparam int OP_W      = 3;
  localparam int SPEED_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int BASE_W    = 15;
  localparam int LIMIT_W   = 19;
  localparam int SUM_W     = 20;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 19;

  typedef enum logic [OP_W-1:0] {
    OP_RIGHT     = 3'd0,
    OP_LEFT      = 3'd1,
    OP_STRAIGHT  = 3'd2,
    OP_HALT      = 3'd3,
    OP_NOT_FOUND = 3'd4
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PID    = 2'd0,
    ACT_HALT   = 2'd1,
    ACT_SEARCH = 2'd2
  } act_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM   = 3'd5;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P    = 16'd2458;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I    = 16'd205;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D    = 16'd1229;
  localparam logic [BASE_W-1:0]  RST_BASE      = 15'd560;
  localparam logic [LIMIT_W-1:0] RST_INT_LIMIT = 19'd4800;
  localparam logic [BASE_W-1:0]  RST_MAX_RPM   = 15'd2880;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [BASE_W-1:0]  cruise_speed;
    logic [LIMIT_W-1:0] sum_limit;
    logic [BASE_W-1:0]  max_rpm;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    act_t               action;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [SUM_W-1:0]   error_sum;
    logic [SPEED_W-1:0] last_error;
  } state_upd_t;

endpackage

`default_nettype wire

/* design/lfps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lfps_cfg_regs: configuration register file
// Six write-only registers loaded from the plain write port and truncated to
// their own widths. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfps_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output lfps_pkg::cfg_t                       cfg
);
  import lfps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:    cfg_nxt.gain_p       = cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I:    cfg_nxt.gain_i       = cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:    cfg_nxt.gain_d       = cfg_wdata[GAIN_W-1:0];
        CFG_BASE:      cfg_nxt.cruise_speed = cfg_wdata[BASE_W-1:0];
        CFG_INT_LIMIT: cfg_nxt.sum_limit    = cfg_wdata[LIMIT_W-1:0];
        CFG_MAX_RPM:   cfg_nxt.max_rpm      = cfg_wdata[BASE_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= RST_GAIN_P;
      cfg_r.gain_i       <= RST_GAIN_I;
      cfg_r.gain_d       <= RST_GAIN_D;
      cfg_r.cruise_speed <= RST_BASE;
      cfg_r.sum_limit    <= RST_INT_LIMIT;
      cfg_r.max_rpm      <= RST_MAX_RPM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* design/lfps_pid_core.sv */
// ----------------------------------------------------------------------------
// lfps_pid_core: one-step steering datapath
// Forms the error for a command, updates the clamped integral, computes the
// three gain products, scales the sum and clamps both wheel speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_pid_core (
  input  wire logic [lfps_pkg::OP_W-1:0]     op,
  input  wire logic [lfps_pkg::SPEED_W-1:0]  offset,
  input  lfps_pkg::cfg_t                     cfg,
  input  wire logic [lfps_pkg::SUM_W-1:0]    error_sum,
  input  wire logic [lfps_pkg::SPEED_W-1:0]  last_error,
  output lfps_pkg::result_t                  res,
  output lfps_pkg::state_upd_t               upd
);
  import lfps_pkg::*;

  logic signed [SPEED_W-1:0]   err;
  logic signed [SPEED_W-1:0]   off_s;
  logic signed [SUM_W-1:0]     sum_in;
  logic signed [SUM_W:0]       acc;
  logic signed [SUM_W:0]       lim;
  logic signed [SUM_W-1:0]     sum_new;
  logic signed [SPEED_W:0]     deriv;
  logic signed [32:0]          p_term;
  logic signed [36:0]          i_term;
  logic signed [33:0]          d_term;
  logic signed [38:0]          total;
  logic signed [26:0]          pid;
  logic signed [27:0]          base_x;
  logic signed [27:0]          max_x;
  logic signed [27:0]          left_raw;
  logic signed [27:0]          right_raw;
  logic signed [27:0]          left_c;
  logic signed [27:0]          right_c;
  logic                        steer;

  assign off_s = $signed(offset);

  always_comb begin
    err    = '0;
    sum_in = $signed(error_sum);
    steer  = 1'b0;
    unique case (op)
      OP_RIGHT: begin
        err   = off_s;
        steer = 1'b1;
      end
      OP_LEFT: begin
        // The most negative offset has no positive twin and saturates.
        err   = (off_s == 16'sh8000) ? 16'sh7fff : -off_s;
        steer = 1'b1;
      end
      OP_STRAIGHT: begin
        sum_in = $signed(error_sum) >>> 1;
        steer  = 1'b1;
      end
      default: begin
        err = '0;
      end
    endcase
  end

  always_comb begin
    acc = {sum_in[SUM_W-1], sum_in} + {{(SUM_W+1-SPEED_W){err[SPEED_W-1]}}, err};
    lim = $signed({2'b00, cfg.sum_limit});
    if (acc > lim) begin
      acc = lim;
    end else if (acc < -lim) begin
      acc = -lim;
    end
    sum_new = acc[SUM_W-1:0];
  end

  assign deriv  = {err[SPEED_W-1], err} - {last_error[SPEED_W-1], last_error};
  assign p_term = $signed({1'b0, cfg.gain_p}) * err;
  assign i_term = $signed({1'b0, cfg.gain_i}) * sum_new;
  assign d_term = $signed({1'b0, cfg.gain_d}) * deriv;
  assign total  = {{6{p_term[32]}}, p_term} + {{2{i_term[36]}}, i_term}
                + {{5{d_term[33]}}, d_term};
  // Arithmetic shift gives the floor of the Q4.12 scaling.
  assign pid    = total[38:12];

  assign base_x    = $signed({13'd0, cfg.cruise_speed});
  assign max_x     = $signed({13'd0, cfg.max_rpm});
  assign left_raw  = base_x + {pid[26], pid};
  assign right_raw = base_x - {pid[26], pid};

  always_comb begin
    left_c = left_raw;
    if (left_raw > max_x) begin
      left_c = max_x;
    end else if (left_raw < -max_x) begin
      left_c = -max_x;
    end
    right_c = right_raw;
    if (right_raw > max_x) begin
      right_c = max_x;
    end else if (right_raw < -max_x) begin
      right_c = -max_x;
    end
  end

  always_comb begin
    res.valid       = 1'b1;
    res.left_speed  = left_c[SPEED_W-1:0];
    res.right_speed = right_c[SPEED_W-1:0];
    res.action      = ACT_PID;
    upd.we          = 1'b1;
    upd.error_sum   = sum_new;
    upd.last_error  = err;
    unique case (op)
      OP_HALT: begin
        res.left_speed  = '0;
        res.right_speed = '0;
        res.action      = ACT_HALT;
        upd.error_sum   = '0;
        upd.last_error  = '0;
      end
      OP_NOT_FOUND: begin
        res.left_speed  = -{1'b0, cfg.cruise_speed};
        res.right_speed = {1'b0, cfg.cruise_speed};
        res.action      = ACT_SEARCH;
        upd.error_sum   = '0;
        upd.last_error  = '0;
      end
      default: begin
        res.valid = steer;
        upd.we    = steer;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/line_follow_pid_steering.sv */
// ----------------------------------------------------------------------------
// line_follow_pid_steering: PID line-follow steering for a two-wheel drive
// Turns right, left, straight, halt and not-found commands into wheel speeds.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries a command code and a signed
//   Q11.4 line offset. The result channel (out_valid/out_ready) returns the
//   left and right wheel speeds in Q11.4 rpm and an action code. Unknown
//   commands are consumed and produce no result word.
//   A word accepted lands in the input register; the datapath
//   (three gain multipliers, the integral clamp and the wheel clamps) fills
//   the result register from it whenever the result register can advance.
//   One word per cycle is sustained while the receiver takes results; that
//   pass through the multipliers sets the clock.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word; input ready drops only while
//   both are full.
//   Reset clears both registers' valid flags, the integral and the previous
//   error, and loads the default gains and limits. The user writes cfg_ port
//   registers only with no command in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_pid_steering (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lfps_pkg::OP_W-1:0]       in_operation,
  input  wire logic [lfps_pkg::SPEED_W-1:0]    in_offset,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lfps_pkg::SPEED_W-1:0]         out_left_speed,
  output logic [lfps_pkg::SPEED_W-1:0]         out_right_speed,
  output logic [lfps_pkg::ACT_W-1:0]           out_action,
  input  wire logic                            cfg_we,
  input  wire logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfps_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import lfps_pkg::*;

  cfg_t                cfg;
  result_t             res;
  state_upd_t          upd;

  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [SPEED_W-1:0]  s1_offset_r;
  logic                out_valid_r;
  logic [SPEED_W-1:0]  out_left_r;
  logic [SPEED_W-1:0]  out_right_r;
  act_t                out_action_r;
  logic [SUM_W-1:0]    error_sum_r;
  logic [SPEED_W-1:0]  last_error_r;
  logic                advance;
  logic                s1_valid_nxt;
  logic                out_valid_nxt;

  lfps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfps_pid_core u_core (
    .op         (s1_op_r),
    .offset     (s1_offset_r),
    .cfg        (cfg),
    .error_sum  (error_sum_r),
    .last_error (last_error_r),
    .res        (res),
    .upd        (upd)
  );

  // The result register can take a new word when empty or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && advance && upd.we) begin
        error_sum_r  <= upd.error_sum;
        last_error_r <= upd.last_error;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r     <= in_operation;
      s1_offset_r <= in_offset;
    end
    if (advance && s1_valid_r) begin
      out_left_r   <= res.left_speed;
      out_right_r  <= res.right_speed;
      out_action_r <= res.action;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_speed  = out_left_r;
  assign out_right_speed = out_right_r;
  assign out_action      = out_action_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while the result register is empty");

  a_halt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && (s1_op_r == OP_HALT || s1_op_r == OP_NOT_FOUND))
    |=> (error_sum_r == '0 && last_error_r == '0))
    else $error("halt or not-found did not clear the controller state");

  a_unknown_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && !res.valid)
    |=> (!out_valid_r && $stable(error_sum_r) && $stable(last_error_r)))
    else $error("unknown command produced a result or changed the state");

  a_result_action: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && s1_op_r == OP_HALT)
    |=> (out_valid_r && out_action_r == ACT_HALT && out_left_r == '0))
    else $error("halt result word is wrong");

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the line-follow PID steering block
// Drives steering, halt, not-found and reserved commands through the input
// channel under bursty traffic and a stalling receiver, predicts each result
// word with its own integral and derivative state, and compares every field
// in order. Gains, speeds and limits are rewritten between phases, extremes
// included.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfps_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_CMDS   = 105;
  localparam int RAND_PHASES  = 10;
  localparam int DRAIN_CYCLES = 6;

  // Command codes and register indexes that the block decodes as unused.
  localparam logic [OP_W-1:0]      OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0]      OP_RSVD_MID   = 3'd6;
  localparam logic [OP_W-1:0]      OP_RSVD_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SPEED_W-1:0] offset;
  } steer_cmd_t;

  typedef struct {
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
    act_t               act;
  } wheel_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = '0;
  logic [SPEED_W-1:0]   in_offset = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SPEED_W-1:0]   out_left_speed;
  logic [SPEED_W-1:0]   out_right_speed;
  logic [ACT_W-1:0]     out_action;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  line_follow_pid_steering u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_offset       (in_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_speed  (out_left_speed),
    .out_right_speed (out_right_speed),
    .out_action      (out_action),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the register file.
  logic [GAIN_W-1:0]  k_p       = RST_GAIN_P;
  logic [GAIN_W-1:0]  k_i       = RST_GAIN_I;
  logic [GAIN_W-1:0]  k_d       = RST_GAIN_D;
  logic [BASE_W-1:0]  cruise    = RST_BASE;
  logic [LIMIT_W-1:0] integ_cap = RST_INT_LIMIT;
  logic [BASE_W-1:0]  rpm_cap   = RST_MAX_RPM;

  // Controller state as the block should hold it.
  longint integ_acc = 0;
  longint prev_err  = 0;

  steer_cmd_t cmd_backlog[$];
  wheel_cmd_t owed_speeds[$];
  int         speeds_owed = 0;
  int         n_bad = 0;
  int         quiet_cycles = 0;

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advances the controller state by one command; returns 0 when the command
  // produces no word.
  function automatic bit steer_wheels(input logic [OP_W-1:0] op,
                                      input logic signed [SPEED_W-1:0] off,
                                      output wheel_cmd_t w);
    longint e, s, d, pid;
    w.act = ACT_PID;
    case (op)
      OP_HALT: begin
        integ_acc = 0;
        prev_err  = 0;
        w.left  = '0;
        w.right = '0;
        w.act   = ACT_HALT;
        return 1'b1;
      end
      OP_NOT_FOUND: begin
        integ_acc = 0;
        prev_err  = 0;
        w.left  = 16'(-longint'(cruise));
        w.right = 16'(longint'(cruise));
        w.act   = ACT_SEARCH;
        return 1'b1;
      end
      OP_RIGHT: e = longint'(off);
      OP_LEFT: begin
        // Negating the most negative offset saturates.
        e = -longint'(off);
        if (e > 32767) e = 32767;
      end
      OP_STRAIGHT: begin
        e = 0;
        integ_acc = integ_acc >>> 1;
      end
      default: return 1'b0;
    endcase
    s = clip(integ_acc + e, longint'(integ_cap));
    integ_acc = s;
    d = e - prev_err;
    prev_err = e;
    pid = (longint'(k_p) * e + longint'(k_i) * s + longint'(k_d) * d) >>> 12;
    w.left  = 16'(clip(longint'(cruise) + pid, longint'(rpm_cap)));
    w.right = 16'(clip(longint'(cruise) - pid, longint'(rpm_cap)));
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string what, input logic [15:0] want,
                              input logic [15:0] got);
    if (n_bad < 10)
      $display("mismatch %s at %0t: expected 0x%h, got 0x%h", what, $realtime, want, got);
    n_bad++;
  endtask

  // Sender: bursts of random length, random gaps, and a full drain of the
  // result channel after every eighth burst.
  int  burst_left = 0;
  int  gap_left = 0;
  int  burst_no = 0;
  bit  draining = 1'b0;

  always @(posedge clk) begin
    steer_cmd_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
      burst_no   <= 0;
      draining   <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (draining) begin
        if (!in_valid && speeds_owed == 0) draining <= 1'b0;
        in_valid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        in_valid     <= 1'b1;
        in_operation <= nxt.op;
        in_offset    <= nxt.offset;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          burst_no   <= burst_no + 1;
          draining   <= (burst_no % 8 == 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a rotating ready pattern, redrawn whenever the 6-bit age counter wraps.
  logic [15:0] ready_pat = '1;
  logic [5:0]  pat_age = '0;

  always @(posedge clk) begin
    logic [15:0] pat;
    pat = ready_pat;
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0: pat = '1;
        1: pat = 16'($urandom);
        default: pat = 16'($urandom | $urandom);
      endcase
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= pat[0];
    end
    ready_pat <= {pat[0], pat[15:1]};
    pat_age   <= pat_age + 1'b1;
  end

  // Monitor: check the word leaving, then predict for the word entering.
  always @(posedge clk) begin
    wheel_cmd_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_speeds.size() == 0) begin
          log_mismatch("word with nothing pending", '0, out_left_speed);
        end else begin
          want = owed_speeds.pop_front();
          if (out_left_speed !== want.left)
            log_mismatch("left_speed", want.left, out_left_speed);
          if (out_right_speed !== want.right)
            log_mismatch("right_speed", want.right, out_right_speed);
          if (out_action !== want.act)
            log_mismatch("action", 16'(want.act), 16'(out_action));
        end
      end
      if (in_valid && in_ready) begin
        if (steer_wheels(in_operation, in_offset, want)) owed_speeds.push_back(want);
      end
      speeds_owed <= owed_speeds.size();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("line_follow_pid_steering regression: fail");
      $finish;
    end
  end

  function automatic void queue_cmd(input logic [OP_W-1:0] op, input logic [15:0] off);
    steer_cmd_t c;
    c.op = op;
    c.offset = off;
    cmd_backlog.push_back(c);
  endfunction

  // Register value: zero, all ones (the register's maximum once masked) or
  // a random word, with bits above the width of the narrower registers.
  function automatic logic [CFG_DAT_W-1:0] pick_reg();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return CFG_DAT_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GAIN_P:    k_p = val[GAIN_W-1:0];
      CFG_GAIN_I:    k_i = val[GAIN_W-1:0];
      CFG_GAIN_D:    k_d = val[GAIN_W-1:0];
      CFG_BASE:      cruise = val[BASE_W-1:0];
      CFG_INT_LIMIT: integ_cap = val[LIMIT_W-1:0];
      CFG_MAX_RPM:   rpm_cap = val[BASE_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every word is in and every result is out, then lets any
  // reserved command still in the pipeline pass.
  task automatic settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || speeds_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int known;
    int r;
    logic [OP_W-1:0]    op;
    logic [SPEED_W-1:0] off;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass under the default registers.
    @(negedge clk);
    queue_cmd(OP_RIGHT, 16'h0000);
    queue_cmd(OP_RIGHT, 16'h7FFF);
    queue_cmd(OP_LEFT, 16'h8000);
    queue_cmd(OP_RIGHT, 16'h8000);
    queue_cmd(OP_STRAIGHT, 16'h1234);
    queue_cmd(OP_STRAIGHT, 16'h0000);
    queue_cmd(OP_LEFT, 16'h7FFF);
    queue_cmd(OP_RIGHT, 16'hFFFF);
    queue_cmd(OP_LEFT, 16'h0001);
    queue_cmd(OP_RSVD_FIRST, 16'h5555);
    queue_cmd(OP_HALT, 16'hAAAA);
    queue_cmd(OP_RIGHT, 16'h0050);
    queue_cmd(OP_RSVD_MID, 16'hAAAA);
    queue_cmd(OP_NOT_FOUND, 16'h5555);
    queue_cmd(OP_STRAIGHT, 16'h0000);
    queue_cmd(OP_RSVD_LAST, 16'hFFFF);
    queue_cmd(OP_RIGHT, 16'hFFFD);
    queue_cmd(OP_STRAIGHT, 16'h0000);
    queue_cmd(OP_STRAIGHT, 16'h0000);
    queue_cmd(OP_HALT, 16'h0000);
    queue_cmd(OP_LEFT, 16'h0200);
    settle();

    for (int p = 1; p <= RAND_PHASES; p++) begin
      case (p)
        1: begin
          // Integral pinned at zero and both wheels pinned at zero on steering commands.
          write_reg(CFG_GAIN_P, pick_reg());
          write_reg(CFG_GAIN_I, pick_reg());
          write_reg(CFG_GAIN_D, pick_reg());
          write_reg(CFG_BASE, pick_reg());
          write_reg(CFG_INT_LIMIT, '0);
          write_reg(CFG_MAX_RPM, '0);
        end
        2: begin
          write_reg(CFG_GAIN_P, '1);
          write_reg(CFG_GAIN_I, '1);
          write_reg(CFG_GAIN_D, '1);
          write_reg(CFG_BASE, '1);
          write_reg(CFG_INT_LIMIT, '1);
          write_reg(CFG_MAX_RPM, '1);
        end
        3: begin
          // The wide integral left by the previous phase gets clamped.
          write_reg(CFG_INT_LIMIT, 19'd100);
          write_reg(CFG_GAIN_P, pick_reg());
          write_reg(CFG_GAIN_I, pick_reg());
          write_reg(CFG_GAIN_D, pick_reg());
          write_reg(CFG_BASE, pick_reg());
          write_reg(CFG_MAX_RPM, pick_reg());
        end
        4: begin
          write_reg(CFG_GAIN_P, '0);
          write_reg(CFG_GAIN_I, '0);
          write_reg(CFG_GAIN_D, '0);
          write_reg(CFG_BASE, '0);
          write_reg(CFG_INT_LIMIT, '0);
          write_reg(CFG_MAX_RPM, '0);
          write_reg(CFG_UNUSED_LO, CFG_DAT_W'($urandom));
          write_reg(CFG_UNUSED_HI, '1);
        end
        default: begin
          write_reg(CFG_GAIN_P, pick_reg());
          write_reg(CFG_GAIN_I, pick_reg());
          write_reg(CFG_GAIN_D, pick_reg());
          write_reg(CFG_BASE, pick_reg());
          write_reg(CFG_INT_LIMIT, pick_reg());
          write_reg(CFG_MAX_RPM, pick_reg());
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;

      @(negedge clk);
      known = 0;
      while (known < PHASE_CMDS) begin
        r = $urandom_range(0, 99);
        if (r < 34)      op = OP_RIGHT;
        else if (r < 68) op = OP_LEFT;
        else if (r < 80) op = OP_STRAIGHT;
        else if (r < 86) op = OP_HALT;
        else if (r < 92) op = OP_NOT_FOUND;
        else             op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        case ($urandom_range(0, 7))
          0: off = 16'h7FFF;
          1: off = 16'h8000;
          2, 3: off = 16'($urandom_range(0, 400) - 200);
          default: off = 16'($urandom);
        endcase
        queue_cmd(op, off);
        if (op < OP_RSVD_FIRST) known++;
      end
      settle();
    end

    if (n_bad == 0 && owed_speeds.size() == 0) begin
      $display("line_follow_pid_steering regression: pass");
    end else begin
      $display("line_follow_pid_steering regression: fail");
    end
    $finish;
  end

endmodule
